// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the polyline point block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define PPF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define PPF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/ppf_pkg.sv -----
// Types, codes and constants of the polyline point block.
`default_nettype none
package ppf_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_POINT, S_MUL, S_PRIME, S_WALK, S_WAIT, S_LON, S_LAT, S_FIN
   } state_type;

   localparam int LON_W  = 32;
   localparam int LAT_W  = 31;
   localparam int LEN_W  = 32;
   localparam int BRG_W  = 17;
   localparam int Q_W    = 16;
   localparam int F_W    = 17;
   localparam int NEED_W = LEN_W + Q_W;
   localparam int ANG_W  = 26;
   localparam int CRD_W  = 36;

   localparam logic [4:0] CORDIC_LAST = 5'd16;
   localparam logic [4:0] DIV_LAST    = 5'd16;

   localparam logic signed [ANG_W-1:0] DEG90  = 26'sd5898240;
   localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;
   localparam logic signed [ANG_W-1:0] DEG360 = 26'sd23592960;
   localparam logic [BRG_W-1:0] BEARING_WRAP = 17'd92160;

   typedef struct packed {
      logic signed [LON_W-1:0] lon;
      logic signed [LAT_W-1:0] lat;
      logic [LEN_W-1:0]        len;
   } vertex_type;

   typedef struct packed {
      logic signed [LON_W:0] east;
      logic signed [LAT_W:0] north;
   } vec_type;

   // Arctangent of 2^-i in 1/65536 degree units.
   function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ANG_W-1:0] val;
      unique case (idx)
         5'd0:  val = 26'sd2949120;
         5'd1:  val = 26'sd1740967;
         5'd2:  val = 26'sd919879;
         5'd3:  val = 26'sd466945;
         5'd4:  val = 26'sd234379;
         5'd5:  val = 26'sd117304;
         5'd6:  val = 26'sd58666;
         5'd7:  val = 26'sd29335;
         5'd8:  val = 26'sd14668;
         5'd9:  val = 26'sd7334;
         5'd10: val = 26'sd3667;
         5'd11: val = 26'sd1833;
         5'd12: val = 26'sd917;
         5'd13: val = 26'sd458;
         5'd14: val = 26'sd229;
         5'd15: val = 26'sd115;
         5'd16: val = 26'sd57;
         default: val = 26'sd0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ppf_vertex_mem.sv -----
// Vertex store: one write and one registered read per cycle.
`default_nettype none
module ppf_vertex_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_W-1:0]    waddr,
   input  wire ppf_pkg::vertex_type  wdata,
   input  wire logic                 re,
   input  wire logic [ADDR_W-1:0]    raddr,
   output ppf_pkg::vertex_type       rdata
);

   ppf_pkg::vertex_type mem_q [DEPTH];
   ppf_pkg::vertex_type rdata_ff;

   // Write the loaded vertex, register the read data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_q[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_q[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- rtl/core/ppf_divider.sv -----
// Restoring divider: Q16 fraction within a segment, one quotient bit a cycle.
`default_nettype none
module ppf_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [ppf_pkg::NEED_W-1:0]   need,
   input  wire logic [ppf_pkg::LEN_W-1:0]    len,
   output logic                              done,
   output logic [ppf_pkg::F_W-1:0]           quot
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [4:0]                    step_ff, step_in;
   logic [ppf_pkg::NEED_W-1:0]    rem_ff, rem_in;
   logic [ppf_pkg::NEED_W-1:0]    dsh_ff, dsh_in;
   logic [ppf_pkg::F_W-1:0]       q_ff, q_in;

   // Subtract the shifted divisor where it fits, shift it down
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 5'd0;
         rem_in  = need;
         dsh_in  = {len, {ppf_pkg::Q_W{1'b0}}};
         q_in    = '0;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[ppf_pkg::F_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[ppf_pkg::F_W-2:0], 1'b0};
         end
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff + 5'd1;
         if (step_ff == ppf_pkg::DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
`default_nettype wire

// ----- rtl/core/ppf_cordic.sv -----
// CORDIC vectoring unit: segment bearing in 1/256 degree, one iteration a cycle.
`default_nettype none
module ppf_cordic (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire ppf_pkg::vec_type           vec,
   output logic                            done,
   output logic [ppf_pkg::BRG_W-1:0]       bearing
);

   localparam int CW = ppf_pkg::CRD_W;
   localparam int AW = ppf_pkg::ANG_W;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [4:0]              iter_ff, iter_in;
   logic signed [CW-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [AW-1:0]    z_ff, z_in;
   logic                    east_neg_ff, east_neg_in, north_neg_ff, north_neg_in;
   logic                    ax_zero_ff, ax_zero_in, ay_zero_ff, ay_zero_in;
   logic [ppf_pkg::BRG_W-1:0] brg_ff, brg_in;

   logic signed [CW-1:0]    east_ext, north_ext, ax, ay, xs, ys;
   logic signed [AW-1:0]    z_fin, ang;
   logic signed [AW-1:0]    rnd;

   // Shift the magnitude, keep the sign
   function automatic logic signed [CW-1:0] shr_trunc(input logic signed [CW-1:0] v,
                                                      input logic [4:0] sh);
      logic signed [CW-1:0] r;
      if (v < 0) begin
         r = -((-v) >>> sh);
      end else begin
         r = v >>> sh;
      end
      return r;
   endfunction

   always_comb begin
      east_ext  = CW'(vec.east);
      north_ext = CW'(vec.north);
      ax = (north_ext < 0) ? -north_ext : north_ext;
      ay = (east_ext < 0) ? -east_ext : east_ext;
      xs = shr_trunc(x_ff, iter_ff);
      ys = shr_trunc(y_ff, iter_ff);

      // Pick the first-quadrant angle, place it into its quadrant and round
      if (ay_zero_ff) begin
         z_fin = '0;
      end else if (ax_zero_ff) begin
         z_fin = ppf_pkg::DEG90;
      end else if (z_ff < 0) begin
         z_fin = '0;
      end else if (z_ff > ppf_pkg::DEG90) begin
         z_fin = ppf_pkg::DEG90;
      end else begin
         z_fin = z_ff;
      end
      if (!east_neg_ff) begin
         ang = north_neg_ff ? (ppf_pkg::DEG180 - z_fin) : z_fin;
      end else begin
         ang = north_neg_ff ? (ppf_pkg::DEG180 + z_fin) : (ppf_pkg::DEG360 - z_fin);
      end
      if (ang >= ppf_pkg::DEG360) begin
         ang = ang - ppf_pkg::DEG360;
      end
      rnd = (ang + 26'sd128) >>> 8;

      busy_in      = busy_ff;
      done_in      = 1'b0;
      iter_in      = iter_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      east_neg_in  = east_neg_ff;
      north_neg_in = north_neg_ff;
      ax_zero_in   = ax_zero_ff;
      ay_zero_in   = ay_zero_ff;
      brg_in       = brg_ff;

      if (start) begin
         busy_in      = 1'b1;
         iter_in      = 5'd0;
         x_in         = ax;
         y_in         = ay;
         z_in         = '0;
         east_neg_in  = vec.east < 0;
         north_neg_in = vec.north < 0;
         ax_zero_in   = ax == 0;
         ay_zero_in   = ay == 0;
      end else if (busy_ff) begin
         if (iter_ff > ppf_pkg::CORDIC_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (rnd[ppf_pkg::BRG_W-1:0] >= ppf_pkg::BEARING_WRAP) begin
               brg_in = '0;
            end else begin
               brg_in = rnd[ppf_pkg::BRG_W-1:0];
            end
         end else begin
            // Rotate toward the x axis
            if (y_ff > 0) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + ppf_pkg::atan_entry(iter_ff);
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - ppf_pkg::atan_entry(iter_ff);
            end
            iter_in = iter_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      iter_ff      <= iter_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      east_neg_ff  <= east_neg_in;
      north_neg_ff <= north_neg_in;
      ax_zero_ff   <= ax_zero_in;
      ay_zero_ff   <= ay_zero_in;
      brg_ff       <= brg_in;
   end

   assign done    = done_ff;
   assign bearing = brg_ff;

endmodule
`default_nettype wire

// ----- rtl/core/polyline_point_at_fraction.sv -----
// Polyline point at fraction: top level with vertex store, walk sequencer and interpolation.
//
// Clear, load, unused operation codes and a query on an empty route keep busy
// low, and the result strobes on rsp_valid in the next cycle. A query on a
// single vertex, a fraction at or outside the ends or a zero route length reads
// one end vertex and returns it from S_POINT. Any other query forms the target
// distance in S_MUL, fetches the first vertex in S_PRIME, then walks one stored
// vertex per cycle through the single read port of the store, then runs the
// divider and the CORDIC unit side by side until both results are held in
// S_WAIT, and interpolates in S_LON, S_LAT and S_FIN before the strobe.
// rsp_valid is high for exactly one cycle per result and cannot be held off; a
// new request is taken whenever busy is low, also in the cycle in which a
// result strobes.
`default_nettype none
`include "assert_macros.svh"
module polyline_point_at_fraction #(
   parameter int MAX_VERTICES = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [1:0]                           req_operation,
   input  wire logic signed [ppf_pkg::LON_W-1:0]     req_vertex_lon,
   input  wire logic signed [ppf_pkg::LAT_W-1:0]     req_vertex_lat,
   input  wire logic [ppf_pkg::LEN_W-1:0]            req_segment_length,
   input  wire logic signed [17:0]                   req_fraction,
   output logic                                      rsp_valid,
   output logic [1:0]                                rsp_status,
   output logic signed [ppf_pkg::LON_W-1:0]          rsp_point_lon,
   output logic signed [ppf_pkg::LAT_W-1:0]          rsp_point_lat,
   output logic [ppf_pkg::BRG_W-1:0]                 rsp_bearing,
   output logic                                      rsp_bearing_valid
);

   localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int RL_W   = ppf_pkg::LEN_W + ADDR_W;
   localparam int TGT_W  = RL_W + ppf_pkg::Q_W;
   localparam int PROD_W = ppf_pkg::LON_W + 1 + ppf_pkg::F_W + 1;

   ppf_pkg::state_type             state_ff, state_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [RL_W-1:0]                rl_ff, rl_in;
   logic [ppf_pkg::Q_W-1:0]        frac_ff, frac_in;
   logic [3:0]                     mbit_ff, mbit_in;
   logic [TGT_W-1:0]               tgt_ff, tgt_in;
   logic [RL_W-1:0]                cum_ff, cum_in;
   logic [ADDR_W-1:0]              idx_ff, idx_in;
   ppf_pkg::vertex_type            prev_ff, prev_in, a_ff, a_in, b_ff, b_in;
   logic [ppf_pkg::F_W-1:0]        f_ff, f_in;
   logic                           div_done_ff, div_done_in, cor_done_ff, cor_done_in;
   logic [ppf_pkg::BRG_W-1:0]      brg_ff, brg_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [ppf_pkg::LON_W-1:0] lon_res_ff, lon_res_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;
   logic signed [ppf_pkg::LON_W-1:0] rsp_lon_ff, rsp_lon_in;
   logic signed [ppf_pkg::LAT_W-1:0] rsp_lat_ff, rsp_lat_in;
   logic [ppf_pkg::BRG_W-1:0]      rsp_brg_ff, rsp_brg_in;
   logic                           rsp_bv_ff, rsp_bv_in;

   logic                           mem_we, mem_re;
   logic [ADDR_W-1:0]              mem_waddr, mem_raddr;
   ppf_pkg::vertex_type            mem_wdata, mem_rdata;

   logic                           div_start, div_done, cor_start, cor_done;
   logic [ppf_pkg::NEED_W-1:0]     need;
   logic [ppf_pkg::F_W-1:0]        div_quot;
   ppf_pkg::vec_type               cor_vec;
   logic [ppf_pkg::BRG_W-1:0]      cor_bearing;

   logic [ADDR_W-1:0]              last_idx;
   logic [RL_W-1:0]                sum;
   logic [ppf_pkg::LEN_W-1:0]      load_len;
   logic signed [PROD_W-1:0]       rounded;
   ppf_pkg::op_type                op;

   ppf_vertex_mem #(
      .DEPTH  (MAX_VERTICES),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   ppf_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .need  (need),
      .len   (mem_rdata.len),
      .done  (div_done),
      .quot  (div_quot)
   );

   ppf_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .vec     (cor_vec),
      .done    (cor_done),
      .bearing (cor_bearing)
   );

   assign op       = ppf_pkg::op_type'(req_operation);
   assign last_idx = ADDR_W'(count_ff - CNT_W'(1));
   assign sum      = cum_ff + RL_W'(mem_rdata.len);
   assign need     = ppf_pkg::NEED_W'(tgt_ff - {cum_ff, {ppf_pkg::Q_W{1'b0}}});
   assign load_len = (count_ff == '0) ? '0 : req_segment_length;
   assign rounded  = (prod_ff + PROD_W'(32768)) >>> ppf_pkg::Q_W;
   assign cor_vec.east  = (ppf_pkg::LON_W+1)'(mem_rdata.lon) - (ppf_pkg::LON_W+1)'(prev_ff.lon);
   assign cor_vec.north = (ppf_pkg::LAT_W+1)'(mem_rdata.lat) - (ppf_pkg::LAT_W+1)'(prev_ff.lat);
   assign mem_waddr = count_ff[ADDR_W-1:0];
   assign mem_wdata = '{lon: req_vertex_lon, lat: req_vertex_lat, len: load_len};

   // Sequence requests: load and clear in place, query by reading an end vertex or walking the store
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rl_in         = rl_ff;
      frac_in       = frac_ff;
      mbit_in       = mbit_ff;
      tgt_in        = tgt_ff;
      cum_in        = cum_ff;
      idx_in        = idx_ff;
      prev_in       = prev_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      f_in          = f_ff;
      div_done_in   = div_done_ff;
      cor_done_in   = cor_done_ff;
      brg_in        = brg_ff;
      prod_in       = prod_ff;
      lon_res_in    = lon_res_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_lon_in    = rsp_lon_ff;
      rsp_lat_in    = rsp_lat_ff;
      rsp_brg_in    = rsp_brg_ff;
      rsp_bv_in     = rsp_bv_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      div_start     = 1'b0;
      cor_start     = 1'b0;

      unique case (state_ff)
         ppf_pkg::S_IDLE: begin
            if (start) begin
               rsp_status_in = ppf_pkg::STATUS_OK;
               rsp_lon_in    = '0;
               rsp_lat_in    = '0;
               rsp_brg_in    = '0;
               rsp_bv_in     = 1'b0;
               unique case (op)
                  ppf_pkg::OP_CLEAR: begin
                     count_in     = '0;
                     rl_in        = '0;
                     rsp_valid_in = 1'b1;
                  end
                  ppf_pkg::OP_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= CNT_W'(MAX_VERTICES)) begin
                        rsp_status_in = ppf_pkg::STATUS_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        rl_in    = rl_ff + RL_W'(load_len);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ppf_pkg::OP_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ppf_pkg::STATUS_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else if (count_ff == CNT_W'(1) || req_fraction <= 18'sd0) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        state_in  = ppf_pkg::S_POINT;
                     end else if (req_fraction >= 18'sd65536) begin
                        mem_re    = 1'b1;
                        mem_raddr = last_idx;
                        state_in  = ppf_pkg::S_POINT;
                     end else if (rl_ff == '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        state_in  = ppf_pkg::S_POINT;
                     end else begin
                        frac_in  = req_fraction[ppf_pkg::Q_W-1:0];
                        tgt_in   = '0;
                        mbit_in  = 4'd15;
                        state_in = ppf_pkg::S_MUL;
                     end
                  end
                  ppf_pkg::OP_NONE: begin
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // Return an end vertex without a bearing
         ppf_pkg::S_POINT: begin
            rsp_valid_in = 1'b1;
            rsp_lon_in   = mem_rdata.lon;
            rsp_lat_in   = mem_rdata.lat;
            state_in     = ppf_pkg::S_IDLE;
         end

         // Form target = route length * fraction, one fraction bit a cycle
         ppf_pkg::S_MUL: begin
            tgt_in = (tgt_ff << 1) + (frac_ff[mbit_ff] ? TGT_W'(rl_ff) : '0);
            if (mbit_ff == 4'd0) begin
               mem_re    = 1'b1;
               mem_raddr = '0;
               cum_in    = '0;
               state_in  = ppf_pkg::S_PRIME;
            end else begin
               mbit_in = mbit_ff - 4'd1;
            end
         end

         // Hold the first vertex, read the second
         ppf_pkg::S_PRIME: begin
            prev_in   = mem_rdata;
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(1);
            idx_in    = ADDR_W'(1);
            state_in  = ppf_pkg::S_WALK;
         end

         // Advance one segment a cycle until its end reaches the target or the last vertex is reached
         ppf_pkg::S_WALK: begin
            if ({sum, {ppf_pkg::Q_W{1'b0}}} >= tgt_ff) begin
               a_in        = prev_ff;
               b_in        = mem_rdata;
               cor_start   = 1'b1;
               cor_done_in = 1'b0;
               if (mem_rdata.len == '0) begin
                  f_in        = '0;
                  div_done_in = 1'b1;
               end else begin
                  div_start   = 1'b1;
                  div_done_in = 1'b0;
               end
               state_in = ppf_pkg::S_WAIT;
            end else begin
               cum_in  = sum;
               prev_in = mem_rdata;
               if (idx_ff == last_idx) begin
                  rsp_valid_in = 1'b1;
                  rsp_lon_in   = mem_rdata.lon;
                  rsp_lat_in   = mem_rdata.lat;
                  state_in     = ppf_pkg::S_IDLE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = idx_ff + ADDR_W'(1);
                  idx_in    = idx_ff + ADDR_W'(1);
               end
            end
         end

         // Collect the fraction and the bearing
         ppf_pkg::S_WAIT: begin
            if (div_done) begin
               f_in        = div_quot;
               div_done_in = 1'b1;
            end
            if (cor_done) begin
               brg_in      = cor_bearing;
               cor_done_in = 1'b1;
            end
            if (div_done_ff && cor_done_ff) begin
               state_in = ppf_pkg::S_LON;
            end
         end

         ppf_pkg::S_LON: begin
            prod_in  = PROD_W'((PROD_W)'(b_ff.lon) - (PROD_W)'(a_ff.lon))
                       * $signed({1'b0, f_ff});
            state_in = ppf_pkg::S_LAT;
         end

         ppf_pkg::S_LAT: begin
            lon_res_in = a_ff.lon + rounded[ppf_pkg::LON_W-1:0];
            prod_in    = PROD_W'((PROD_W)'(b_ff.lat) - (PROD_W)'(a_ff.lat))
                         * $signed({1'b0, f_ff});
            state_in   = ppf_pkg::S_FIN;
         end

         ppf_pkg::S_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_lon_in   = lon_res_ff;
            rsp_lat_in   = a_ff.lat + rounded[ppf_pkg::LAT_W-1:0];
            rsp_brg_in   = brg_ff;
            rsp_bv_in    = 1'b1;
            state_in     = ppf_pkg::S_IDLE;
         end

         default: begin
            state_in = ppf_pkg::S_IDLE;
         end
      endcase
   end

   // Hold control state under reset, payload free running
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppf_pkg::S_IDLE;
         count_ff     <= '0;
         rl_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         div_done_ff  <= 1'b0;
         cor_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rl_ff        <= rl_in;
         rsp_valid_ff <= rsp_valid_in;
         div_done_ff  <= div_done_in;
         cor_done_ff  <= cor_done_in;
      end
      frac_ff       <= frac_in;
      mbit_ff       <= mbit_in;
      tgt_ff        <= tgt_in;
      cum_ff        <= cum_in;
      idx_ff        <= idx_in;
      prev_ff       <= prev_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      f_ff          <= f_in;
      brg_ff        <= brg_in;
      prod_ff       <= prod_in;
      lon_res_ff    <= lon_res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_lon_ff    <= rsp_lon_in;
      rsp_lat_ff    <= rsp_lat_in;
      rsp_brg_ff    <= rsp_brg_in;
      rsp_bv_ff     <= rsp_bv_in;
   end

   assign busy              = state_ff != ppf_pkg::S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_point_lon     = rsp_lon_ff;
   assign rsp_point_lat     = rsp_lat_ff;
   assign rsp_bearing       = rsp_brg_ff;
   assign rsp_bearing_valid = rsp_bv_ff;

   `PPF_ASSERT_SAME(a_no_bearing_zero, clock, reset,
      rsp_valid && !rsp_bearing_valid, rsp_bearing == '0)
   `PPF_ASSERT_NEXT(a_short_request, clock, reset,
      start && !busy && req_operation != ppf_pkg::OP_QUERY, rsp_valid)
   `PPF_ASSERT_SAME(a_idle_on_result, clock, reset, busy, !rsp_valid)
   `PPF_ASSERT_SAME(a_fraction_range, clock, reset,
      state_ff == ppf_pkg::S_LON, f_ff <= ppf_pkg::F_W'(65536))

endmodule
`default_nettype wire
